FILE: hdl/fpra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpra_pkg
// Shared types, sizes and codes of the FIFO paired-resource arbiter.
// ----------------------------------------------------------------------------
package fpra_pkg;

  // Sizes of the arbiter.
  localparam int RESOURCE_COUNT = 16;
  localparam int QUEUE_DEPTH    = 16;
  localparam int MAX_RESULTS    = 16;

  // Fixed field widths.
  localparam int ID_W      = 8;
  localparam int IDX_W     = 4;
  localparam int RES_SLOTS = 1 << IDX_W;

  // Derived widths.
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  // Opcodes and result kinds.
  localparam logic OP_REQUEST  = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;
  localparam logic KIND_GRANT  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // One waiting request.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } entry_t;

  // One result item, without its last marker.
  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic grant;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_grant;
  } stat_t;

  // Indices at or above RESOURCE_COUNT name no resource and are never marked.
  function automatic logic [RES_SLOTS-1:0] res_mask();
    logic [RES_SLOTS-1:0] m;
    for (int i = 0; i < RES_SLOTS; i++) begin
      m[i] = (i < RESOURCE_COUNT);
    end
    return m;
  endfunction

  function automatic logic [RES_SLOTS-1:0] res_bit(input logic [IDX_W-1:0] idx);
    return RES_SLOTS'(1) << idx;
  endfunction

  function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fpra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpra_ctrl
// Sequencer: takes one item, then walks the grant cascade at the queue head.
// ----------------------------------------------------------------------------
module fpra_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire fpra_pkg::stat_t stat,
  output fpra_pkg::cmd_t      cmd,
  output logic                busy
);
  import fpra_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.grant  = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        // The head entry is read from the queue memory in this cycle.
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.can_grant) begin
          cmd.grant = 1'b1;
          state_nxt = S_READ;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A grant is always followed by a fresh read of the new head.
  a_grant_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> state_r == S_READ)
    else $error("grant not followed by head read");

  // Accept happens only while not busy.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !busy && start)
    else $error("item taken while busy");

  // A finish always returns the sequencer to idle.
  a_finish_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !busy)
    else $error("finish did not return to idle");

endmodule
`default_nettype wire

FILE: hdl/fpra_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpra_dp
// Datapath: wait queue memory, resource busy marks, pointers and result regs.
// ----------------------------------------------------------------------------
module fpra_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fpra_pkg::cmd_t             cmd,
  output fpra_pkg::stat_t                 stat,
  input  wire logic                       in_opcode,
  input  wire logic [fpra_pkg::ID_W-1:0]  in_requester_id,
  input  wire logic [fpra_pkg::IDX_W-1:0] in_left_index,
  input  wire logic [fpra_pkg::IDX_W-1:0] in_right_index,
  output logic                            out_valid,
  output logic                            out_result_kind,
  output logic [fpra_pkg::ID_W-1:0]       out_granted_id,
  output logic [fpra_pkg::IDX_W-1:0]      out_granted_left,
  output logic [fpra_pkg::IDX_W-1:0]      out_granted_right,
  output logic                            out_last_result
);
  import fpra_pkg::*;

  localparam logic [RES_SLOTS-1:0] RES_MASK = res_mask();

  entry_t               mem [QUEUE_DEPTH];
  entry_t               rd_r;
  logic                 mem_we;
  entry_t               wr_entry;

  logic [RES_SLOTS-1:0] busy_r, busy_nxt;
  logic [QPTR_W-1:0]    head_r, head_nxt;
  logic [QPTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [NRES_W-1:0]    n_r, n_nxt;
  result_t              pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  result_t              out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 full;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign wr_entry = '{id: in_requester_id, left: in_left_index, right: in_right_index};

  assign stat.can_grant = (count_r != '0) && (n_r != NRES_W'(MAX_RESULTS)) &&
                          !busy_r[rd_r.left] && !busy_r[rd_r.right];

  always_comb begin
    busy_nxt      = busy_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;

    if (cmd.accept) begin
      n_nxt = '0;
      if (in_opcode == OP_REQUEST) begin
        if (full) begin
          pend_nxt   = '{kind: KIND_REJECT, id: in_requester_id, left: '0, right: '0};
          pend_v_nxt = 1'b1;
          n_nxt      = NRES_W'(1);
        end else begin
          mem_we    = 1'b1;
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end else begin
        busy_nxt = busy_r & ~(res_bit(in_left_index) | res_bit(in_right_index));
      end
    end

    // A result is held back one step so the last one of an item can be marked.
    if (cmd.grant) begin
      busy_nxt  = busy_r | ((res_bit(rd_r.left) | res_bit(rd_r.right)) & RES_MASK);
      head_nxt  = next_slot(head_r);
      count_nxt = count_r - CNT_W'(1);
      n_nxt     = n_r + NRES_W'(1);
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_nxt   = '{kind: KIND_GRANT, id: rd_r.id, left: rd_r.left, right: rd_r.right};
      pend_v_nxt = 1'b1;
    end

    if (cmd.finish) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b1;
      end
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= wr_entry;
    end
    rd_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_r.kind;
  assign out_granted_id    = out_r.id;
  assign out_granted_left  = out_r.left;
  assign out_granted_right = out_r.right;
  assign out_last_result   = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_grant_pops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("grant did not pop the queue");

  a_finish_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !pend_v_r && (out_valid_r == $past(pend_v_r)))
    else $error("pending result lost at end of item");

  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> (busy_r & ((res_bit($past(rd_r.left)) | res_bit($past(rd_r.right)))
                   & RES_MASK)) == ((res_bit($past(rd_r.left)) | res_bit($past(rd_r.right)))
                   & RES_MASK))
    else $error("granted resources not marked busy");

endmodule
`default_nettype wire

FILE: hdl/fifo_paired_resource_arbiter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_paired_resource_arbiter_top
// Strict FIFO arbiter that grants pairs of shared resources to queued requests.
// ----------------------------------------------------------------------------
// An item is taken in the idle state; then each step of the cascade at the queue
// head is a registered head read followed by a check, and busy stays high until a
// check finds no grant. Each result strobes out_valid for one cycle; the last
// result of an item appears as busy falls. The receiver cannot stall.
// Synchronous reset empties the queue and frees every resource.
module fifo_paired_resource_arbiter_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_opcode,
  input  wire logic [fpra_pkg::ID_W-1:0]  in_requester_id,
  input  wire logic [fpra_pkg::IDX_W-1:0] in_left_index,
  input  wire logic [fpra_pkg::IDX_W-1:0] in_right_index,
  output logic                            out_valid,
  output logic                            out_result_kind,
  output logic [fpra_pkg::ID_W-1:0]       out_granted_id,
  output logic [fpra_pkg::IDX_W-1:0]      out_granted_left,
  output logic [fpra_pkg::IDX_W-1:0]      out_granted_right,
  output logic                            out_last_result
);
  import fpra_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fpra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fpra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (in_opcode),
    .in_requester_id   (in_requester_id),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_granted_id    (out_granted_id),
    .out_granted_left  (out_granted_left),
    .out_granted_right (out_granted_right),
    .out_last_result   (out_last_result)
  );

endmodule
`default_nettype wire

FILE: verif/fifo_paired_resource_arbiter_top_test.sv
// ----------------------------------------------------------------------------
// fifo_paired_resource_arbiter_top_test
// Self-checking bench for the FIFO paired-resource arbiter. A driver sends
// request and release commands in bursts with random gaps. A predictor follows
// the wait line and the busy marks of the resources and works out the grants
// and rejects for each accepted command. A monitor compares every result strobe
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fifo_paired_resource_arbiter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpra_pkg::*;

  localparam int DIRECT_HOLDERS = 14;
  localparam int RANDOM_ITEMS   = 288;
  localparam int SETTLE_CYCLES  = 3 + 2 * MAX_RESULTS + 8;
  localparam int IDLE_LIMIT     = 2000;

  typedef struct {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    bit               drain_first;
  } arb_cmd_t;

  typedef struct packed {
    result_t res;
    logic    last;
  } grant_note_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             in_opcode = OP_REQUEST;
  logic [ID_W-1:0]  in_requester_id = '0;
  logic [IDX_W-1:0] in_left_index = '0;
  logic [IDX_W-1:0] in_right_index = '0;
  logic             busy;
  logic             out_valid;
  logic             out_result_kind;
  logic [ID_W-1:0]  out_granted_id;
  logic [IDX_W-1:0] out_granted_left;
  logic [IDX_W-1:0] out_granted_right;
  logic             out_last_result;

  arb_cmd_t    cmd_backlog[$];
  arb_cmd_t    cmd_on_bus;
  grant_note_t due_results[$];

  // Predictor state: busy marks of the resources and the wait line.
  logic [RES_SLOTS-1:0] res_held = '0;
  entry_t               wait_line[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  fifo_paired_resource_arbiter_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_requester_id   (in_requester_id),
    .in_left_index     (in_left_index),
    .in_right_index    (in_right_index),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_granted_id    (out_granted_id),
    .out_granted_left  (out_granted_left),
    .out_granted_right (out_granted_right),
    .out_last_result   (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic bit res_is_held(input logic [IDX_W-1:0] idx);
    return (int'(idx) < RESOURCE_COUNT) && res_held[idx];
  endfunction

  function automatic void res_mark(input logic [IDX_W-1:0] idx, input logic v);
    if (int'(idx) < RESOURCE_COUNT) begin
      res_held[idx] = v;
    end
  endfunction

  // Applies one accepted command and queues the grants and rejects it causes.
  function automatic void arbitrate_cmd(input arb_cmd_t c);
    entry_t      head;
    entry_t      fresh;
    grant_note_t note;
    int          n;
    n = 0;
    if (c.op == OP_REQUEST) begin
      if (wait_line.size() >= QUEUE_DEPTH) begin
        note.res.kind  = KIND_REJECT;
        note.res.id    = c.id;
        note.res.left  = '0;
        note.res.right = '0;
        note.last      = 1'b0;
        due_results.push_back(note);
        n++;
      end else begin
        fresh.id    = c.id;
        fresh.left  = c.left;
        fresh.right = c.right;
        wait_line.push_back(fresh);
      end
    end else begin
      res_mark(c.left, 1'b0);
      res_mark(c.right, 1'b0);
    end
    // The head blocks everyone behind it; the cascade is capped per command.
    while (n < MAX_RESULTS && wait_line.size() > 0) begin
      head = wait_line[0];
      if (res_is_held(head.left) || res_is_held(head.right)) break;
      res_mark(head.left, 1'b1);
      res_mark(head.right, 1'b1);
      void'(wait_line.pop_front());
      note.res.kind  = KIND_GRANT;
      note.res.id    = head.id;
      note.res.left  = head.left;
      note.res.right = head.right;
      note.last      = 1'b0;
      due_results.push_back(note);
      n++;
    end
    if (n > 0) begin
      due_results[due_results.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void queue_cmd(input logic op, input int id, input int left,
                                    input int right, input bit drain_first);
    arb_cmd_t c;
    c.op          = op;
    c.id          = ID_W'(id);
    c.left        = IDX_W'(left);
    c.right       = IDX_W'(right);
    c.drain_first = drain_first;
    cmd_backlog.push_back(c);
  endfunction

  // Driver: bursts of commands separated by random gaps.
  always @(posedge clk) begin
    bit launch;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      launch = 1'b0;
      if (start) begin
        arbitrate_cmd(cmd_on_bus);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].drain_first && due_results.size() > 0)) begin
        cmd_on_bus = cmd_backlog.pop_front();
        in_opcode       <= cmd_on_bus.op;
        in_requester_id <= cmd_on_bus.id;
        in_left_index   <= cmd_on_bus.left;
        in_right_index  <= cmd_on_bus.right;
        launch = 1'b1;
      end
      start <= launch;
    end
  end

  // Monitor: every strobe is one transfer that must match the oldest prediction.
  always @(posedge clk) begin
    grant_note_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0h", out_result_kind,
                                  out_granted_id));
      end else begin
        want = due_results.pop_front();
        if (out_result_kind !== want.res.kind)
          report_mismatch($sformatf("result_kind got %0d want %0d", out_result_kind,
                                    want.res.kind));
        if (out_granted_id !== want.res.id)
          report_mismatch($sformatf("granted_id got %0h want %0h", out_granted_id,
                                    want.res.id));
        if (out_granted_left !== want.res.left)
          report_mismatch($sformatf("granted_left got %0d want %0d", out_granted_left,
                                    want.res.left));
        if (out_granted_right !== want.res.right)
          report_mismatch($sformatf("granted_right got %0d want %0d", out_granted_right,
                                    want.res.right));
        if (out_last_result !== want.last)
          report_mismatch($sformatf("last_result got %0d want %0d", out_last_result,
                                    want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [2*IDX_W-1:0] held_pairs[$];
    logic [IDX_W-1:0]   l;
    logic [IDX_W-1:0]   r;
    int                 req_pct;
    int                 pct_choice;

    // One holder takes resource 0, then a blocked head and fifteen singles
    // fill the wait line behind it.
    queue_cmd(OP_REQUEST, 8'h00, 0, 0, 1'b0);
    queue_cmd(OP_REQUEST, 8'hA0, 0, 0, 1'b0);
    for (int k = 1; k < 16; k++) begin
      queue_cmd(OP_REQUEST, k, k, k, 1'b0);
    end
    // The line is full, so this one is turned away.
    queue_cmd(OP_REQUEST, 8'hFF, 15, 15, 1'b0);
    // Freeing resource 0 releases the whole line in one cascade.
    queue_cmd(OP_RELEASE, 8'h00, 0, 0, 1'b0);
    queue_cmd(OP_RELEASE, 8'h55, 15, 0, 1'b1);
    // Releasing resources that are already free changes nothing.
    queue_cmd(OP_RELEASE, 8'hAA, 15, 0, 1'b0);
    queue_cmd(OP_REQUEST, 8'h5A, 15, 0, 1'b0);

    for (int k = 1; k <= DIRECT_HOLDERS; k++) begin
      held_pairs.push_back({IDX_W'(k), IDX_W'(k)});
    end
    held_pairs.push_back({IDX_W'(15), IDX_W'(0)});

    req_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        pct_choice = $urandom_range(0, 2);
        req_pct = (pct_choice == 0) ? 30 : (pct_choice == 1) ? 50 : 85;
      end
      if ($urandom_range(0, 99) < req_pct) begin
        l = IDX_W'($urandom_range(0, 15));
        r = ($urandom_range(0, 4) == 0) ? l : IDX_W'($urandom_range(0, 15));
        held_pairs.push_back({l, r});
        queue_cmd(OP_REQUEST, $urandom_range(0, 255), l, r,
                  (i == 0) || ($urandom_range(0, 39) == 0));
      end else begin
        // Mostly release pairs in the order they were asked for, which is the
        // order a strict FIFO hands them out.
        if (held_pairs.size() > 0 && $urandom_range(0, 9) != 0) begin
          {l, r} = held_pairs.pop_front();
        end else begin
          l = IDX_W'($urandom_range(0, 15));
          r = IDX_W'($urandom_range(0, 15));
        end
        queue_cmd(OP_RELEASE, $urandom_range(0, 255), l, r,
                  (i == 0) || ($urandom_range(0, 39) == 0));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (cmd_backlog.size() > 0 || start || due_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
